@@ hdl/sss_pkg.sv @@
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants of the servo swing sequencer.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int POS_WIDTH   = 10;
  localparam int TIME_WIDTH  = 16;
  localparam int CFG_DATA_W  = (TIME_WIDTH > POS_WIDTH) ? TIME_WIDTH : POS_WIDTH;
  localparam int CFG_INDEX_W = 3;

  typedef logic [POS_WIDTH-1:0]   pos_t;
  typedef logic [TIME_WIDTH-1:0]  ticks_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  localparam cfg_index_t REG_LOW_ANGLE   = 3'd0;
  localparam cfg_index_t REG_HIGH_ANGLE  = 3'd1;
  localparam cfg_index_t REG_LOW_DWELL   = 3'd2;
  localparam cfg_index_t REG_HIGH_DWELL  = 3'd3;
  localparam cfg_index_t REG_UP_STEP     = 3'd4;
  localparam cfg_index_t REG_DOWN_STEP   = 3'd5;
  localparam cfg_index_t REG_CONTINUOUS  = 3'd6;

  typedef enum logic [2:0] {
    PH_LOW  = 3'd0,
    PH_UP   = 3'd1,
    PH_HIGH = 3'd2,
    PH_DOWN = 3'd3,
    PH_STOP = 3'd4
  } phase_t;

  typedef struct packed {
    pos_t   low_angle;
    pos_t   high_angle;
    ticks_t low_dwell_ticks;
    ticks_t high_dwell_ticks;
    pos_t   up_step;
    pos_t   down_step;
    logic   continuous_mode;
  } cfg_t;

  typedef struct packed {
    phase_t phase;
    pos_t   position;
    ticks_t tick_count;
  } state_t;

endpackage

@@ hdl/sss_tick.sv @@
// ----------------------------------------------------------------------------
// sss_tick
// Next-state logic of one sequencer tick: dwell counting, clamped ramps and
// phase changes.
// ----------------------------------------------------------------------------
module sss_tick (
  input  sss_pkg::cfg_t   cfg,
  input  sss_pkg::state_t cur,
  input  logic            advance,
  output sss_pkg::state_t nxt
);
  import sss_pkg::*;

  logic [POS_WIDTH:0] up_sum;
  pos_t               down_span;
  pos_t               down_diff;

  assign up_sum    = {1'b0, cur.position} + {1'b0, cfg.up_step};
  assign down_span = cur.position - cfg.low_angle;
  assign down_diff = cur.position - cfg.down_step;

  always_comb begin
    nxt = cur;
    if (advance) begin
      case (cur.phase)
        PH_LOW: begin
          if (cur.tick_count < cfg.low_dwell_ticks) begin
            nxt.tick_count = cur.tick_count + 1'b1;
          end else if (cur.position > cfg.high_angle) begin
            nxt.phase = PH_DOWN;
          end else begin
            nxt.phase = PH_UP;
          end
        end
        PH_UP: begin
          if (cur.position < cfg.high_angle) begin
            if (up_sum > {1'b0, cfg.high_angle}) begin
              nxt.position = cfg.high_angle;
            end else begin
              nxt.position = up_sum[POS_WIDTH-1:0];
            end
          end else begin
            nxt.phase      = PH_HIGH;
            nxt.tick_count = '0;
            nxt.position   = cfg.high_angle;
          end
        end
        PH_HIGH: begin
          if (cur.tick_count < cfg.high_dwell_ticks) begin
            nxt.tick_count = cur.tick_count + 1'b1;
          end else begin
            nxt.phase = PH_DOWN;
          end
        end
        PH_DOWN: begin
          if (cur.position > cfg.low_angle) begin
            if (cfg.down_step >= down_span) begin
              nxt.position = cfg.low_angle;
            end else begin
              nxt.position = down_diff;
            end
          end else begin
            nxt.tick_count = '0;
            nxt.position   = cfg.low_angle;
            nxt.phase      = cfg.continuous_mode ? PH_LOW : PH_STOP;
          end
        end
        default: begin
          nxt.phase = PH_STOP;
        end
      endcase
    end
  end

endmodule

@@ hdl/servo_swing_sequencer.sv @@
// ----------------------------------------------------------------------------
// servo_swing_sequencer
// Servo swing position generator, one tick per transfer with advance set.
// ----------------------------------------------------------------------------
// Path: input register, then the combinational tick pass, then the result
//   register; an output stall holds the item in the input register.
// Throughput: one item per cycle while the output is not stalled.
// Reset: state to low dwell, position and tick count zero, registers to
//   their defaults, both stages empty.
module servo_swing_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  sss_pkg::cfg_index_t cfg_index,
  input  sss_pkg::cfg_data_t  cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                advance,
  output logic                out_valid,
  input  logic                out_stall,
  output sss_pkg::pos_t       position,
  output logic [2:0]          phase,
  output logic                stopped
);
  import sss_pkg::*;

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  logic   held;
  logic   held_advance;
  logic   fire;

  assign in_stall = held && out_valid && out_stall;
  assign fire     = held && !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_angle        <= '0;
      cfg.high_angle       <= '1;
      cfg.low_dwell_ticks  <= '0;
      cfg.high_dwell_ticks <= '0;
      cfg.up_step          <= pos_t'(1);
      cfg.down_step        <= pos_t'(1);
      cfg.continuous_mode  <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LOW_ANGLE:  cfg.low_angle        <= cfg_data[POS_WIDTH-1:0];
        REG_HIGH_ANGLE: cfg.high_angle       <= cfg_data[POS_WIDTH-1:0];
        REG_LOW_DWELL:  cfg.low_dwell_ticks  <= cfg_data[TIME_WIDTH-1:0];
        REG_HIGH_DWELL: cfg.high_dwell_ticks <= cfg_data[TIME_WIDTH-1:0];
        REG_UP_STEP:    cfg.up_step          <= cfg_data[POS_WIDTH-1:0];
        REG_DOWN_STEP:  cfg.down_step        <= cfg_data[POS_WIDTH-1:0];
        REG_CONTINUOUS: cfg.continuous_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held <= 1'b1;
    end else if (fire) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_advance <= advance;
    end
  end

  sss_tick u_tick (
    .cfg     (cfg),
    .cur     (st),
    .advance (held_advance),
    .nxt     (st_next)
  );

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= PH_LOW;
      st.position   <= '0;
      st.tick_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (fire) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      position <= st_next.position;
      phase    <= st_next.phase;
      stopped  <= (st_next.phase == PH_STOP);
    end
  end

  a_stop_sticks: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_STOP |=> st.phase == PH_STOP)
    else $error("stopped phase left without reset");

  a_state_only_on_fire: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(st))
    else $error("state changed without a tick pass");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    held && out_valid && out_stall |=> held && $stable(held_advance))
    else $error("held input item lost under output stall");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    $past(fire) && !$past(rst) |-> position == st.position && phase == st.phase)
    else $error("result register differs from state");

endmodule
